/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ACSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("acsr assertion failed");

// Clocked assertion that stays active during reset.
`define ACSR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("acsr assertion failed");

`endif

/* src/acsr_pkg.sv */
package acsr_pkg;

    localparam int ReqTypeW  = 2;
    localparam int AngleW    = 9;
    localparam int RangeW    = 16;
    localparam int SpeedW    = 16;
    localparam int SpeedMagW = 15;
    localparam int TargetW   = 15;
    localparam int TtcW      = 16;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam logic [ReqTypeW-1:0] REQ_RANGE = 2'd0;
    localparam logic [ReqTypeW-1:0] REQ_FRONT = 2'd1;
    localparam logic [ReqTypeW-1:0] REQ_REAR  = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_RANGE_LOWER = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_UPPER = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_TARGET      = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TTC_LOW     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TTC_HIGH    = 3'd4;

    localparam logic [RangeW-1:0]  RST_RANGE_LOWER = 16'd20;
    localparam logic [RangeW-1:0]  RST_RANGE_UPPER = 16'd30000;
    localparam logic [TargetW-1:0] RST_TARGET      = 15'd500;
    localparam logic [TtcW-1:0]    RST_TTC_LOW     = 16'd5000;
    localparam logic [TtcW-1:0]    RST_TTC_HIGH    = 16'd7000;

    localparam logic [RangeW-1:0] NO_TARGET = 16'd33000;
    localparam logic [RangeW-1:0] WARN_MM   = 16'd300;
    localparam logic [RangeW-1:0] NEAR_MM   = 16'd600;
    localparam logic [RangeW-1:0] FAR_MM    = 16'd800;

    localparam int CmdW = 18;
    localparam logic signed [CmdW-1:0] SLOW_REAR   = 18'sd100;
    localparam logic signed [CmdW-1:0] REL_CLOSE   = 18'sd100;
    localparam logic signed [CmdW-1:0] REL_OPEN    = 18'sd250;
    localparam logic signed [CmdW-1:0] STOP_REAR   = 18'sd1;
    localparam logic signed [CmdW-1:0] STEP_SMALL  = 18'sd7;
    localparam logic signed [CmdW-1:0] STEP_MED    = 18'sd10;
    localparam logic signed [CmdW-1:0] STEP_BRAKE  = 18'sd130;
    localparam logic signed [CmdW-1:0] CMD_MAX     = 18'sd32767;
    localparam logic signed [CmdW-1:0] CMD_MIN     = -18'sd32768;

    localparam logic [31:0] MS_PER_S   = 32'd1000;
    localparam logic [16:0] TTC_MARGIN = 17'd200;

    typedef struct packed {
        logic [RangeW-1:0]  range_lower;
        logic [RangeW-1:0]  range_upper;
        logic [TargetW-1:0] target;
        logic [TtcW-1:0]    ttc_low;
        logic [TtcW-1:0]    ttc_high;
    } t_cfg;

    typedef struct packed {
        logic [ReqTypeW-1:0]      req_type;
        logic [AngleW-1:0]        angle_index;
        logic [RangeW-1:0]        range_mm;
        logic                     last_of_scan;
        logic signed [SpeedW-1:0] speed_mm_s;
    } t_req;

endpackage

/* src/acsr_if.sv */
interface acsr_in_if;
    logic                               valid;
    logic                               ready;
    logic [acsr_pkg::ReqTypeW-1:0]      req_type;
    logic [acsr_pkg::AngleW-1:0]        angle_index;
    logic [acsr_pkg::RangeW-1:0]        range_mm;
    logic                               last_of_scan;
    logic signed [acsr_pkg::SpeedW-1:0] speed_mm_s;

    modport source (output valid, req_type, angle_index, range_mm, last_of_scan, speed_mm_s,
                    input ready);
    modport sink (input valid, req_type, angle_index, range_mm, last_of_scan, speed_mm_s,
                  output ready);
endinterface

interface acsr_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [acsr_pkg::SpeedW-1:0] rear_speed_cmd;
    logic                               collision_warning;
    logic [acsr_pkg::RangeW-1:0]        nearest_mm;

    modport source (output valid, rear_speed_cmd, collision_warning, nearest_mm,
                    input ready);
    modport sink (input valid, rear_speed_cmd, collision_warning, nearest_mm,
                  output ready);
endinterface

/* src/adaptive_cruise_speed_rule_top.sv */
// Adaptive cruise speed rule. Takes front and rear speed updates (negatives
// clamp to zero) and laser range samples; keeps the nearest valid range in
// the forward sector and, on the last sample of a scan, issues one result
// with the new rear speed command, the collision warning and the nearest
// range, then rearms the minimum to 33000 mm. One item is accepted every
// cycle while the output is not stalled; each item is held in the input
// register, and a last-of-scan sample's result is registered into the
// result register as the sample leaves the input register. The rate is set
// by the combinational path from the input register through the sector
// test, the two time-to-collision products and the rule chain into the
// result register. Input ready drops only while a last-of-scan item waits behind a result that has not been taken.
module adaptive_cruise_speed_rule_top #(
    parameter int SCAN_POINTS = 360,
    parameter int SECTOR_HALF = 90
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    acsr_in_if.sink                        i_in,
    acsr_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [acsr_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [acsr_pkg::CfgDataW-1:0]  i_cfg_data
);

    localparam int SectorLo = SCAN_POINTS - SECTOR_HALF;

    acsr_pkg::t_cfg                      w_cfg;
    acsr_pkg::t_req                      r_req;
    logic                                r_req_valid;
    logic [acsr_pkg::RangeW-1:0]         r_nearest;
    logic [acsr_pkg::SpeedMagW-1:0]      r_front;
    logic [acsr_pkg::SpeedMagW-1:0]      r_rear;
    logic signed [acsr_pkg::SpeedW-1:0]  r_cmd;
    logic                                r_out_valid;
    logic signed [acsr_pkg::SpeedW-1:0]  r_out_cmd;
    logic                                r_out_warn;
    logic [acsr_pkg::RangeW-1:0]         r_out_nearest;

    logic                                w_is_range;
    logic                                w_has_result;
    logic                                w_adv;
    logic                                w_in_sector;
    logic                                w_take;
    logic [acsr_pkg::RangeW-1:0]         n_nearest;
    logic [acsr_pkg::SpeedMagW-1:0]      w_speed_clamp;
    logic signed [acsr_pkg::SpeedW-1:0]  w_rule_cmd;
    logic                                w_rule_warn;

    acsr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_is_range   = r_req.req_type == acsr_pkg::REQ_RANGE;
    assign w_has_result = w_is_range && r_req.last_of_scan;
    assign w_adv        = r_req_valid && (!w_has_result || !r_out_valid || o_out.ready);
    assign i_in.ready   = !r_req_valid || w_adv;

    assign w_in_sector = (int'(r_req.angle_index) <= SECTOR_HALF)
                      || (int'(r_req.angle_index) < SCAN_POINTS
                          && int'(r_req.angle_index) > SectorLo);
    assign w_take      = w_in_sector
                      && (w_cfg.range_lower < r_req.range_mm)
                      && (r_req.range_mm < w_cfg.range_upper)
                      && (r_req.range_mm < r_nearest);
    assign n_nearest   = w_take ? r_req.range_mm : r_nearest;

    assign w_speed_clamp = r_req.speed_mm_s[acsr_pkg::SpeedW-1]
                         ? '0 : r_req.speed_mm_s[acsr_pkg::SpeedMagW-1:0];

    acsr_rule u_rule (
        .i_cfg      (w_cfg),
        .i_nearest  (n_nearest),
        .i_front    (r_front),
        .i_rear     (r_rear),
        .i_prev_cmd (r_cmd),
        .o_cmd      (w_rule_cmd),
        .o_warn     (w_rule_warn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_req_valid <= 1'b1;
        end else if (w_adv) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.req_type     <= i_in.req_type;
            r_req.angle_index  <= i_in.angle_index;
            r_req.range_mm     <= i_in.range_mm;
            r_req.last_of_scan <= i_in.last_of_scan;
            r_req.speed_mm_s   <= i_in.speed_mm_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nearest <= acsr_pkg::NO_TARGET;
            r_front   <= '0;
            r_rear    <= '0;
            r_cmd     <= '0;
        end else if (w_adv) begin
            case (r_req.req_type)
                acsr_pkg::REQ_FRONT: r_front <= w_speed_clamp;
                acsr_pkg::REQ_REAR:  r_rear <= w_speed_clamp;
                acsr_pkg::REQ_RANGE: begin
                    if (r_req.last_of_scan) begin
                        r_nearest <= acsr_pkg::NO_TARGET;
                        r_cmd     <= w_rule_cmd;
                    end else begin
                        r_nearest <= n_nearest;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_has_result) begin
            r_out_cmd     <= w_rule_cmd;
            r_out_warn    <= w_rule_warn;
            r_out_nearest <= n_nearest;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.rear_speed_cmd    = r_out_cmd;
    assign o_out.collision_warning = r_out_warn;
    assign o_out.nearest_mm        = r_out_nearest;

endmodule

/* src/acsr_cfg.sv */
module acsr_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acsr_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [acsr_pkg::CfgDataW-1:0]   i_cfg_data,
    output acsr_pkg::t_cfg                  o_cfg
);

    acsr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_lower <= acsr_pkg::RST_RANGE_LOWER;
            r_cfg.range_upper <= acsr_pkg::RST_RANGE_UPPER;
            r_cfg.target      <= acsr_pkg::RST_TARGET;
            r_cfg.ttc_low     <= acsr_pkg::RST_TTC_LOW;
            r_cfg.ttc_high    <= acsr_pkg::RST_TTC_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acsr_pkg::CFG_RANGE_LOWER: r_cfg.range_lower <= i_cfg_data;
                acsr_pkg::CFG_RANGE_UPPER: r_cfg.range_upper <= i_cfg_data;
                acsr_pkg::CFG_TARGET:      r_cfg.target <= i_cfg_data[acsr_pkg::TargetW-1:0];
                acsr_pkg::CFG_TTC_LOW:     r_cfg.ttc_low <= i_cfg_data;
                acsr_pkg::CFG_TTC_HIGH:    r_cfg.ttc_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/acsr_rule.sv */
module acsr_rule (
    input  acsr_pkg::t_cfg                      i_cfg,
    input  logic [acsr_pkg::RangeW-1:0]         i_nearest,
    input  logic [acsr_pkg::SpeedMagW-1:0]      i_front,
    input  logic [acsr_pkg::SpeedMagW-1:0]      i_rear,
    input  logic signed [acsr_pkg::SpeedW-1:0]  i_prev_cmd,
    output logic signed [acsr_pkg::SpeedW-1:0]  o_cmd,
    output logic                                o_warn
);

    localparam int W = acsr_pkg::CmdW;

    logic signed [W-1:0]              w_rear;
    logic signed [W-1:0]              w_rel;
    logic signed [W-1:0]              w_tgt;
    logic signed [W-1:0]              w_neg_rel;
    logic [acsr_pkg::SpeedMagW-1:0]   w_mag;
    logic [31:0]                      w_num;
    logic [31:0]                      w_low_p;
    logic [31:0]                      w_high_p;
    logic                             w_ttc_neg;
    logic                             w_ttc_low;
    logic                             w_ttc_high;
    logic                             w_near;
    logic signed [W-1:0]              n_cmd;

    assign w_rear    = $signed({3'b000, i_rear});
    assign w_rel     = $signed({3'b000, i_front}) - w_rear;
    assign w_tgt     = $signed({3'b000, i_cfg.target});
    assign w_neg_rel = -w_rel;
    assign w_ttc_neg = !w_rel[W-1];
    assign w_mag     = w_ttc_neg ? '0 : w_neg_rel[acsr_pkg::SpeedMagW-1:0];

    assign w_num    = {16'd0, i_nearest} * acsr_pkg::MS_PER_S;
    assign w_low_p  = {16'd0, i_cfg.ttc_low} * {17'd0, w_mag};
    assign w_high_p = {15'd0, {1'b0, i_cfg.ttc_high} + acsr_pkg::TTC_MARGIN} * {17'd0, w_mag};

    assign w_ttc_low  = !w_ttc_neg && (w_num < w_low_p);
    assign w_ttc_high = !w_ttc_neg && (w_num > w_high_p);
    assign w_near     = i_nearest < acsr_pkg::NEAR_MM;
    assign o_warn     = i_nearest < acsr_pkg::WARN_MM;

    always_comb begin
        n_cmd = W'(i_prev_cmd);
        if (w_ttc_low || w_near) begin
            n_cmd = w_rear - acsr_pkg::STEP_SMALL;
        end
        if (w_near && w_rear < acsr_pkg::SLOW_REAR) begin
            n_cmd = w_rear - acsr_pkg::STEP_MED;
        end
        if ((w_ttc_neg || w_ttc_high) && i_nearest > acsr_pkg::FAR_MM && n_cmd < w_tgt) begin
            n_cmd = w_rear + acsr_pkg::STEP_SMALL;
        end
        if (i_nearest == acsr_pkg::NO_TARGET || (w_rel > acsr_pkg::REL_CLOSE && n_cmd < w_tgt)) begin
            n_cmd = w_rear + acsr_pkg::STEP_MED;
        end
        if (n_cmd >= w_tgt) begin
            n_cmd = w_tgt;
        end
        if (w_rear <= acsr_pkg::STOP_REAR) begin
            n_cmd = '0;
        end
        if (w_ttc_neg && w_rel > acsr_pkg::REL_OPEN && n_cmd < w_tgt) begin
            n_cmd = w_rear + acsr_pkg::STEP_MED;
        end
        if (o_warn) begin
            n_cmd = w_rear - acsr_pkg::STEP_BRAKE;
        end
        if (n_cmd > acsr_pkg::CMD_MAX) begin
            n_cmd = acsr_pkg::CMD_MAX;
        end else if (n_cmd < acsr_pkg::CMD_MIN) begin
            n_cmd = acsr_pkg::CMD_MIN;
        end
    end

    assign o_cmd = n_cmd[acsr_pkg::SpeedW-1:0];

endmodule

/* src/acsr_checker.sv */
`include "assert_macros.svh"

module acsr_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [acsr_pkg::SpeedW-1:0] i_out_cmd,
    input  logic                               i_out_warn,
    input  logic [acsr_pkg::RangeW-1:0]        i_out_nearest
);

    `ACSR_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `ACSR_ASSERT(a_out_stable, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> $stable(i_out_cmd) && $stable(i_out_warn)
            && $stable(i_out_nearest))
    `ACSR_ASSERT(a_warn_range, i_clk, i_rst_n,
        i_out_valid |-> i_out_warn == (i_out_nearest < acsr_pkg::WARN_MM))
    `ACSR_ASSERT(a_nearest_cap, i_clk, i_rst_n, i_out_valid |-> i_out_nearest <= acsr_pkg::NO_TARGET)
    `ACSR_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind adaptive_cruise_speed_rule_top acsr_checker u_acsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_cmd     (o_out.rear_speed_cmd),
    .i_out_warn    (o_out.collision_warning),
    .i_out_nearest (o_out.nearest_mm)
);
